/* design/text_terminal_cursor_scroll_core_defines.svh */
// Assertion macros for the text terminal core design file.
`ifndef TEXT_TERMINAL_CURSOR_SCROLL_CORE_DEFINES_SVH
`define TEXT_TERMINAL_CURSOR_SCROLL_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Property checked while reset is released.
`define TTCS_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);
// Property checked on every edge, reset included.
`define TTCS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) \
        else $error(msg);
`else
`define TTCS_ASSERT(label, clk, rstn, prop, msg)
`define TTCS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

/* design/ttcs_pkg.sv */
// Shared types, constants and helpers of the text terminal engine.
`default_nettype none

package ttcs_pkg;

    // Screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;
    localparam int CELL_AW = $clog2(CELLS);

    // Field widths
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CELL_W = 16;

    // Character and attribute codes
    localparam logic [7:0] CHAR_BLANK   = 8'h20;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] RESET_ATTR   = 8'h0F;

    // Request codes
    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_BKSP  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } in_word_t;

    typedef struct packed {
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic [CELL_W-1:0] cell_value;
        logic              did_scroll;
    } out_word_t;

    // Write request into the screen store
    typedef struct packed {
        logic               en;
        logic [CELL_AW-1:0] addr;
        logic [CELL_W-1:0]  data;
    } ram_wr_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SCROLL,
        ST_DRAIN,
        ST_FILL,
        ST_FINISH
    } state_t;

    // Linear cell address of a cursor position
    function automatic logic [CELL_AW-1:0] cell_addr(
        input logic [ROW_W-1:0] row,
        input logic [COL_W-1:0] col
    );
        logic [CELL_AW-1:0] base;
        base = CELL_AW'(row) * CELL_AW'(COLUMNS);
        return base + CELL_AW'(col);
    endfunction

endpackage

`default_nettype wire

/* design/ttcs_screen_ram.sv */
// Screen cell store: one write port, one registered read port.
`default_nettype none

module ttcs_screen_ram (
    input  wire                          aclk,
    input  wire ttcs_pkg::ram_wr_t       wr,
    input  wire                          rd_en,
    input  wire [ttcs_pkg::CELL_AW-1:0]  rd_addr,
    output logic [ttcs_pkg::CELL_W-1:0]  rd_data
);

    logic [ttcs_pkg::CELL_W-1:0] mem [ttcs_pkg::CELLS];
    logic [ttcs_pkg::CELL_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* design/text_terminal_cursor_scroll_core.sv */
// Top level of the text terminal engine: cursor, sequencer and screen store.
//
// Channels: s_valid/s_ready/s_data take one request word (put character,
// backspace, clear, read cell); m_valid/m_ready/m_data return one result word
// per request with the cursor after the request, read data and a scroll flag.
// cfg_valid/cfg_ready/cfg_data write the attribute byte; cfg_ready is always
// high and the write is meant for idle periods only.
// Put, newline, backspace and out-of-range reads go from accept through the
// execute and finish states to m_valid; an in-range read adds the read state.
// A request that scrolls walks the store through the single RAM port pair,
// copying one cell a cycle, then drains. Clear writes one cell a cycle.
// One request is in work at a time: the next word waits until the sequencer
// returns to idle. s_ready is high only when the sequencer is idle, so a new
// word is taken while an earlier result still waits.
// After reset the store is blanked by a pass over all CELLS cells with
// s_ready low; configuration writes are taken during that pass.
// If the receiver stalls, the result stays in the output register, and a
// finished request waits in the finish state until that register frees up.
`default_nettype none
`include "text_terminal_cursor_scroll_core_defines.svh"

module text_terminal_cursor_scroll_core (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  wire ttcs_pkg::in_word_t  s_data,
    output logic                 m_valid,
    input  wire                  m_ready,
    output ttcs_pkg::out_word_t  m_data,
    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire [7:0]            cfg_data
);

    localparam logic [ttcs_pkg::CELL_AW-1:0] LAST_CELL = ttcs_pkg::CELL_AW'(ttcs_pkg::CELLS - 1);
    localparam logic [ttcs_pkg::CELL_AW-1:0] COPY_END  =
        ttcs_pkg::CELL_AW'(ttcs_pkg::CELLS - ttcs_pkg::COLUMNS);
    localparam logic [ttcs_pkg::CELL_AW-1:0] ROW_STEP  = ttcs_pkg::CELL_AW'(ttcs_pkg::COLUMNS);
    localparam logic [ttcs_pkg::COL_W-1:0]   LAST_COL  = ttcs_pkg::COL_W'(ttcs_pkg::COLUMNS - 1);
    localparam logic [ttcs_pkg::ROW_W-1:0]   LAST_ROW  = ttcs_pkg::ROW_W'(ttcs_pkg::ROWS - 1);

    ttcs_pkg::state_t state_reg, state_next;
    ttcs_pkg::in_word_t item_reg, item_next;
    logic [ttcs_pkg::COL_W-1:0]   cur_col_reg, cur_col_next;
    logic [ttcs_pkg::ROW_W-1:0]   cur_row_reg, cur_row_next;
    logic [7:0]                   attr_reg, attr_next;
    logic [ttcs_pkg::CELL_AW-1:0] cnt_reg, cnt_next;
    logic                         init_reg, init_next;
    logic [ttcs_pkg::CELL_W-1:0]  value_reg, value_next;
    logic                         scroll_reg, scroll_next;
    ttcs_pkg::out_word_t          out_reg, out_next;
    logic                         out_valid_reg, out_valid_next;

    // Copy pipeline: each write lands in the cycle after its read
    logic [ttcs_pkg::CELL_AW-1:0] wr_addr_reg, wr_addr_next;
    logic                         wr_copy_reg, wr_copy_next;
    logic                         wr_pend_reg, wr_pend_next;

    ttcs_pkg::ram_wr_t            ram_wr;
    logic                         rd_en;
    logic [ttcs_pkg::CELL_AW-1:0] rd_addr;
    logic [ttcs_pkg::CELL_W-1:0]  rd_data;

    logic [ttcs_pkg::CELL_W-1:0]  blank_cell;
    logic [ttcs_pkg::COL_W-1:0]   bs_col;
    logic [ttcs_pkg::ROW_W-1:0]   bs_row;
    logic                         s_fire;
    logic                         out_free;

    assign blank_cell = {attr_reg, ttcs_pkg::CHAR_BLANK};
    assign s_ready    = (state_reg == ttcs_pkg::ST_IDLE);
    assign s_fire     = s_valid && s_ready;
    assign out_free   = !out_valid_reg || m_ready;
    assign cfg_ready  = 1'b1;
    assign m_valid    = out_valid_reg;
    assign m_data     = out_reg;

    // Cursor position after a backspace
    always_comb begin
        if (cur_col_reg == '0) begin
            bs_col = LAST_COL;
            bs_row = (cur_row_reg != '0) ? cur_row_reg - 1'b1 : cur_row_reg;
        end else begin
            bs_col = cur_col_reg - 1'b1;
            bs_row = cur_row_reg;
        end
    end

    // Sequencer: next state, cursor update and RAM port control
    always_comb begin
        state_next     = state_reg;
        item_next      = item_reg;
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        attr_next      = attr_reg;
        cnt_next       = cnt_reg;
        init_next      = init_reg;
        value_next     = value_reg;
        scroll_next    = scroll_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        wr_addr_next   = wr_addr_reg;
        wr_copy_next   = 1'b0;
        wr_pend_next   = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = item_reg.cell_index;
        ram_wr.en      = 1'b0;
        ram_wr.addr    = wr_addr_reg;
        ram_wr.data    = wr_copy_reg ? rd_data : blank_cell;

        if (cfg_valid) begin
            attr_next = cfg_data;
        end

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ttcs_pkg::ST_IDLE: begin
                if (s_fire) begin
                    item_next   = s_data;
                    value_next  = '0;
                    scroll_next = 1'b0;
                    state_next  = ttcs_pkg::ST_EXEC;
                end
            end

            ttcs_pkg::ST_EXEC: begin
                state_next = ttcs_pkg::ST_FINISH;
                unique case (item_reg.req_type)
                    ttcs_pkg::REQ_PUT: begin
                        if (item_reg.char_code != ttcs_pkg::CHAR_NEWLINE) begin
                            ram_wr.en   = 1'b1;
                            ram_wr.addr = ttcs_pkg::cell_addr(cur_row_reg, cur_col_reg);
                            ram_wr.data = {attr_reg, item_reg.char_code};
                        end
                        if (item_reg.char_code == ttcs_pkg::CHAR_NEWLINE ||
                            cur_col_reg == LAST_COL) begin
                            cur_col_next = '0;
                            if (cur_row_reg == LAST_ROW) begin
                                scroll_next = 1'b1;
                                cnt_next    = '0;
                                state_next  = ttcs_pkg::ST_SCROLL;
                            end else begin
                                cur_row_next = cur_row_reg + 1'b1;
                            end
                        end else begin
                            cur_col_next = cur_col_reg + 1'b1;
                        end
                    end
                    ttcs_pkg::REQ_BKSP: begin
                        cur_col_next = bs_col;
                        cur_row_next = bs_row;
                        ram_wr.en    = 1'b1;
                        ram_wr.addr  = ttcs_pkg::cell_addr(bs_row, bs_col);
                        ram_wr.data  = blank_cell;
                    end
                    ttcs_pkg::REQ_CLEAR: begin
                        cur_col_next = '0;
                        cur_row_next = '0;
                        cnt_next     = '0;
                        state_next   = ttcs_pkg::ST_FILL;
                    end
                    ttcs_pkg::REQ_READ: begin
                        if (item_reg.cell_index < ttcs_pkg::CELL_AW'(ttcs_pkg::CELLS)) begin
                            rd_en      = 1'b1;
                            state_next = ttcs_pkg::ST_READ;
                        end
                    end
                    default: begin
                        state_next = ttcs_pkg::ST_FINISH;
                    end
                endcase
            end

            ttcs_pkg::ST_READ: begin
                value_next = rd_data;
                state_next = ttcs_pkg::ST_FINISH;
            end

            // Copy row r to row r-1, then blank the bottom row
            ttcs_pkg::ST_SCROLL: begin
                ram_wr.en    = wr_pend_reg;
                wr_pend_next = 1'b1;
                wr_addr_next = cnt_reg;
                if (cnt_reg < COPY_END) begin
                    rd_en        = 1'b1;
                    rd_addr      = cnt_reg + ROW_STEP;
                    wr_copy_next = 1'b1;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_CELL) begin
                    state_next = ttcs_pkg::ST_DRAIN;
                end
            end

            ttcs_pkg::ST_DRAIN: begin
                ram_wr.en  = wr_pend_reg;
                state_next = ttcs_pkg::ST_FINISH;
            end

            // Blank sweep for clear and for the pass after reset
            ttcs_pkg::ST_FILL: begin
                ram_wr.en   = 1'b1;
                ram_wr.addr = cnt_reg;
                ram_wr.data = init_reg ? {ttcs_pkg::RESET_ATTR, ttcs_pkg::CHAR_BLANK}
                                       : blank_cell;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == LAST_CELL) begin
                    init_next  = 1'b0;
                    state_next = init_reg ? ttcs_pkg::ST_IDLE : ttcs_pkg::ST_FINISH;
                end
            end

            ttcs_pkg::ST_FINISH: begin
                if (out_free) begin
                    out_next.cursor_col = cur_col_reg;
                    out_next.cursor_row = cur_row_reg;
                    out_next.cell_value = value_reg;
                    out_next.did_scroll = scroll_reg;
                    out_valid_next      = 1'b1;
                    state_next          = ttcs_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = ttcs_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ttcs_pkg::ST_FILL;
            init_reg      <= 1'b1;
            cnt_reg       <= '0;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            attr_reg      <= ttcs_pkg::RESET_ATTR;
            out_valid_reg <= 1'b0;
            wr_pend_reg   <= 1'b0;
            wr_copy_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            cnt_reg       <= cnt_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            attr_reg      <= attr_next;
            out_valid_reg <= out_valid_next;
            wr_pend_reg   <= wr_pend_next;
            wr_copy_reg   <= wr_copy_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        item_reg    <= item_next;
        value_reg   <= value_next;
        scroll_reg  <= scroll_next;
        out_reg     <= out_next;
        wr_addr_reg <= wr_addr_next;
    end

    ttcs_screen_ram u_screen_ram (
        .aclk    (aclk),
        .wr      (ram_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Checks
    `TTCS_ASSERT(a_cursor_range, aclk, aresetn,
        cur_col_reg <= LAST_COL && cur_row_reg <= LAST_ROW,
        "cursor left the screen")
    `TTCS_ASSERT(a_ready_after_init, aclk, aresetn,
        s_ready |-> !init_reg,
        "request taken before the store was blanked")
    `TTCS_ASSERT(a_copy_in_sweep, aclk, aresetn,
        wr_pend_reg |-> (state_reg == ttcs_pkg::ST_SCROLL || state_reg == ttcs_pkg::ST_DRAIN),
        "scroll write pending outside the sweep")
    `TTCS_ASSERT(a_scroll_cursor, aclk, aresetn,
        (m_valid && m_data.did_scroll) |->
            (m_data.cursor_col == '0 && m_data.cursor_row == LAST_ROW),
        "scroll result with cursor off the bottom line start")
    `TTCS_ASSERT_ALWAYS(a_reset_fill, aclk,
        !aresetn |=> (state_reg == ttcs_pkg::ST_FILL && init_reg && !m_valid),
        "reset did not start the blanking pass")

endmodule

`default_nettype wire
